>>> rtl/weighted_random_source_selector_top_macros.svh
// Assertion macros for the weighted random source selector.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef WEIGHTED_RANDOM_SOURCE_SELECTOR_TOP_MACROS_SVH
`define WEIGHTED_RANDOM_SOURCE_SELECTOR_TOP_MACROS_SVH

// Same-cycle implication
`define WRSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WRSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wrss_pkg.sv
// Shared types and constants of the weighted random source selector.
// No dependencies.
package wrss_pkg;

  localparam int MAX_SOURCES_DEF = 16;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int RANDOM_BITS_DEF = 24;

  localparam int CMD_W    = 3;
  localparam int WEIGHT_W = 16;
  localparam int EIDX_W   = 4;
  localparam int RAND_W   = 24;
  localparam int STATUS_W = 2;
  localparam int SRC_W    = 4;
  localparam int SCNT_W   = 5;

  localparam int EIDX_LSB    = WEIGHT_W;
  localparam int RAND_LSB    = WEIGHT_W + EIDX_W;
  localparam int S_FIELDS_W  = WEIGHT_W + EIDX_W + RAND_W;
  localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W  = SRC_W + SCNT_W;
  localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_GENERATE = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_SELECT   = 3'd2,
    CMD_SET      = 3'd3,
    CMD_DELETE   = 3'd4,
    CMD_CLEAR    = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

>>> rtl/weighted_random_source_selector_top.sv
// Weighted random source selector: weight table in a one-port-read synchronous RAM.
// Single generate makes two walks over the RAM read port and a bit-serial multiply; multi
// generate gives N results, one per cycle while the output is not stalled. One request at a time.
// Reset: one entry, current entry 0, single mode; entry 0 reads as 1 until written.
// Depends on wrss_pkg and weighted_random_source_selector_top_macros.svh.
`include "weighted_random_source_selector_top_macros.svh"

module weighted_random_source_selector_top #(
  parameter int MAX_SOURCES = wrss_pkg::MAX_SOURCES_DEF,
  parameter int WEIGHT_BITS = wrss_pkg::WEIGHT_BITS_DEF,
  parameter int RANDOM_BITS = wrss_pkg::RANDOM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_data_i,    // multi_mode
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [wrss_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // weight, entry_index, random_fraction
  input  logic [wrss_pkg::CMD_W-1:0]      s_axis_tuser,  // command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [wrss_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // source_index, source_count
  output logic [wrss_pkg::STATUS_W-1:0]   m_axis_tuser,  // status
  output logic                            m_axis_tlast
);
  import wrss_pkg::*;

  localparam int IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
  localparam int CMP_W  = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;
  localparam int SUM_W  = WEIGHT_BITS + IDX_W;
  localparam int PROD_W = SUM_W + RANDOM_BITS;
  localparam int BIT_W  = $clog2(RANDOM_BITS);
  localparam int MPAD_W = M_TDATA_W - M_FIELDS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DEL   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_MULTI = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       cur_q, cur_d;
  logic                   curv_q, curv_d;
  logic                   multi_q, multi_d;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic [SUM_W-1:0]       acc_q, acc_d;
  logic [SUM_W-1:0]       tot_q, tot_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [RANDOM_BITS-1:0] mr_q, mr_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [IDX_W-1:0]       didx_q, didx_d;
  status_e                pst_q, pst_d;
  logic [IDX_W-1:0]       pidx_q, pidx_d;
  logic                   w0_set_q;
  logic                   rvld_q, rd0_q;
  logic [IDX_W-1:0]       ridx_q;
  logic [WEIGHT_BITS-1:0] rdata_q;
  logic                   m_valid_q;
  status_e                m_status_q;
  logic [SRC_W-1:0]       m_idx_q;
  logic [SCNT_W-1:0]      m_cnt_q;
  logic                   m_last_q;

  logic [WEIGHT_BITS-1:0] mem_q [MAX_SOURCES];

  logic                   in_acc, oready, rd_en, we;
  logic [IDX_W-1:0]       raddr, waddr;
  logic [WEIGHT_BITS-1:0] wdata, rd_data, w_in;
  logic [EIDX_W-1:0]      idx_raw;
  logic [IDX_W-1:0]       idx_in;
  logic                   idx_ok, full, cur_ok;
  logic [RANDOM_BITS-1:0] r_in;
  logic [SUM_W-1:0]       pre;
  cmd_e                   cmd;
  logic                   load, ld_last;
  status_e                ld_status;
  logic [IDX_W-1:0]       ld_idx;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign oready        = !m_valid_q || m_axis_tready;

  assign cmd     = cmd_e'(s_axis_tuser);
  assign w_in    = WEIGHT_BITS'(s_axis_tdata[WEIGHT_W-1:0]);
  assign idx_raw = s_axis_tdata[EIDX_LSB +: EIDX_W];
  assign idx_in  = IDX_W'(idx_raw);
  assign r_in    = RANDOM_BITS'(s_axis_tdata[RAND_LSB +: RAND_W]);
  assign idx_ok  = CMP_W'(idx_raw) < CMP_W'(cnt_q);
  assign full    = cnt_q >= CNT_W'(MAX_SOURCES);
  assign cur_ok  = curv_q && (CNT_W'(cur_q) < cnt_q);

  assign rd_en   = ((state_q == S_SUM) || (state_q == S_SCAN) || (state_q == S_DEL))
                   && (ptr_q < cnt_q);
  assign raddr   = ptr_q[IDX_W-1:0];
  assign rd_data = rd0_q ? WEIGHT_BITS'(1) : rdata_q;
  assign pre     = acc_q + SUM_W'(rd_data);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = w_in;
    if (state_q == S_DEL) begin
      we    = rvld_q;
      waddr = ridx_q - IDX_W'(1);
      wdata = rd_data;
    end else if (in_acc && (cmd == CMD_ADD) && !full) begin
      we    = 1'b1;
      waddr = cnt_q[IDX_W-1:0];
    end else if (in_acc && (cmd == CMD_SET) && cur_ok) begin
      we    = 1'b1;
      waddr = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    curv_d    = curv_q;
    multi_d   = multi_q;
    ptr_d     = ptr_q;
    acc_d     = acc_q;
    tot_d     = tot_q;
    prod_d    = prod_q;
    mr_d      = mr_q;
    bit_d     = bit_q;
    didx_d    = didx_q;
    pst_d     = pst_q;
    pidx_d    = pidx_q;
    load      = 1'b0;
    ld_status = ST_OK;
    ld_idx    = pidx_q;
    ld_last   = 1'b1;
    if (cfg_valid_i) begin
      multi_d = cfg_data_i;
    end
    if (rd_en) begin
      ptr_d = ptr_q + CNT_W'(1);
    end
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        pst_d   = ST_OK;
        pidx_d  = cur_q;
        state_d = S_EMIT;
        case (cmd)
          CMD_GENERATE: begin
            if (cnt_q == '0) begin
              pst_d = ST_EMPTY;
            end else if (multi_q) begin
              ptr_d   = '0;
              state_d = S_MULTI;
            end else if (cnt_q == CNT_W'(1)) begin
              pidx_d = '0;
            end else begin
              ptr_d   = '0;
              acc_d   = '0;
              mr_d    = r_in;
              state_d = S_SUM;
            end
          end
          CMD_ADD: begin
            if (full) begin
              pst_d = ST_FULL;
            end else begin
              cur_d  = cnt_q[IDX_W-1:0];
              curv_d = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
              pidx_d = cnt_q[IDX_W-1:0];
            end
          end
          CMD_SELECT: begin
            if (idx_ok) begin
              cur_d  = idx_in;
              curv_d = 1'b1;
              pidx_d = idx_in;
            end else begin
              pst_d = ST_BAD_INDEX;
            end
          end
          CMD_SET: begin
            if (!cur_ok) begin
              pst_d = ST_EMPTY;
            end
          end
          CMD_DELETE: begin
            if (idx_ok) begin
              didx_d  = idx_in;
              ptr_d   = CNT_W'(idx_raw) + CNT_W'(1);
              state_d = S_DEL;
            end else begin
              pst_d = ST_BAD_INDEX;
            end
          end
          CMD_CLEAR: begin
            cnt_d  = '0;
            cur_d  = '0;
            curv_d = 1'b0;
            pidx_d = '0;
          end
          default: ;
        endcase
      end
      S_SUM: begin
        if (rvld_q) begin
          acc_d = pre;
        end else if (!rd_en) begin
          if (acc_q == '0) begin
            pst_d   = ST_EMPTY;
            pidx_d  = cur_q;
            state_d = S_EMIT;
          end else begin
            tot_d   = acc_q;
            prod_d  = '0;
            bit_d   = '0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d = {prod_q[PROD_W-2:0], 1'b0}
                 + (mr_q[RANDOM_BITS-1] ? PROD_W'(tot_q) : PROD_W'(0));
        mr_d   = {mr_q[RANDOM_BITS-2:0], 1'b0};
        bit_d  = bit_q + BIT_W'(1);
        if (bit_q == BIT_W'(RANDOM_BITS - 1)) begin
          ptr_d   = '0;
          acc_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rvld_q) begin
          acc_d = pre;
          if (prod_q <= {pre, {RANDOM_BITS{1'b0}}}) begin
            pst_d   = ST_OK;
            pidx_d  = ridx_q;
            state_d = S_EMIT;
          end
        end else if (!rd_en) begin
          pst_d   = ST_OK;
          pidx_d  = IDX_W'(cnt_q - CNT_W'(1));
          state_d = S_EMIT;
        end
      end
      S_DEL: begin
        if (!rd_en && !rvld_q) begin
          cnt_d = cnt_q - CNT_W'(1);
          if (cur_q == didx_q) begin
            cur_d  = '0;
            curv_d = curv_q && (cnt_q > CNT_W'(1));
          end else if (cur_q > didx_q) begin
            cur_d = cur_q - IDX_W'(1);
          end
          pst_d   = ST_OK;
          pidx_d  = cur_d;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (oready) begin
          load      = 1'b1;
          ld_status = pst_q;
          ld_idx    = pidx_q;
          state_d   = S_IDLE;
        end
      end
      S_MULTI: begin
        if (oready) begin
          load    = 1'b1;
          ld_idx  = ptr_q[IDX_W-1:0];
          ld_last = (ptr_q + CNT_W'(1)) == cnt_q;
          ptr_d   = ptr_q + CNT_W'(1);
          if (ld_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= CNT_W'(1);
      cur_q     <= '0;
      curv_q    <= 1'b1;
      multi_q   <= 1'b0;
      ptr_q     <= '0;
      bit_q     <= '0;
      w0_set_q  <= 1'b0;
      rvld_q    <= 1'b0;
      rd0_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      curv_q  <= curv_d;
      multi_q <= multi_d;
      ptr_q   <= ptr_d;
      bit_q   <= bit_d;
      rvld_q  <= rd_en;
      if (rd_en) begin
        rd0_q <= (raddr == '0) && !w0_set_q;
      end
      if (we && (waddr == '0)) begin
        w0_set_q <= 1'b1;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    tot_q  <= tot_d;
    prod_q <= prod_d;
    mr_q   <= mr_d;
    didx_q <= didx_d;
    pst_q  <= pst_d;
    pidx_q <= pidx_d;
    if (rd_en) begin
      ridx_q <= raddr;
    end
    if (load) begin
      m_status_q <= ld_status;
      m_idx_q    <= SRC_W'(ld_idx);
      m_cnt_q    <= SCNT_W'(cnt_q);
      m_last_q   <= ld_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {{MPAD_W{1'b0}}, m_cnt_q, m_idx_q};

  `WRSS_ASSERT_IMP(a_cur_in_table, curv_q, CNT_W'(cur_q) < cnt_q, "current entry beyond table")
  `WRSS_ASSERT_IMP(a_write_phase, we, (state_q == S_IDLE) || (state_q == S_DEL), "RAM write during walk")
  `WRSS_ASSERT_NXT(a_idle_hold, (state_q == S_IDLE) && !in_acc, state_q == S_IDLE, "left idle without request")
  `WRSS_ASSERT_IMP(a_count_bound, in_acc, cnt_q <= CNT_W'(MAX_SOURCES), "entry count beyond table size")

endmodule

>>> test/weighted_random_source_selector_top_tb.sv
// Self-checking bench for weighted_random_source_selector_top: directed and random commands
// with idle and stall bursts, predicted by a table model held in the bench.
// Depends on wrss_pkg and the top level of the selector.
module weighted_random_source_selector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wrss_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int TABLE_DEPTH   = MAX_SOURCES_DEF;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 2000;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [WEIGHT_W-1:0] weight;
    logic [EIDX_W-1:0]   entry;
    logic [RAND_W-1:0]   fraction;
    bit                  hold;
  } request_t;

  typedef struct {
    status_e           status;
    logic [SRC_W-1:0]  source;
    logic              last;
    logic [SCNT_W-1:0] count;
  } result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_data_i    = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [CMD_W-1:0]     s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;
  logic                 m_axis_tlast;

  request_t pending_requests[$];
  result_t  expected_results[$];
  request_t cur_request;
  bit       results_drained = 1'b1;
  bit       no_idle = 1'b0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       quiet_cycles = 0;
  int       mismatches = 0;

  logic [WEIGHT_W-1:0] tbl_weight[TABLE_DEPTH];
  logic [SCNT_W-1:0]   tbl_count = SCNT_W'(1);
  logic [SRC_W-1:0]    cur_index = '0;
  bit                  cur_valid = 1'b1;
  bit                  multi_mode = 1'b0;

  weighted_random_source_selector_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic void expect_result(status_e st, logic [SRC_W-1:0] idx, logic last);
    result_t r;
    r.status = st;
    r.source = idx;
    r.last   = last;
    r.count  = tbl_count;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void apply_command(request_t req);
    logic [63:0] total;
    logic [63:0] prefix;
    logic [63:0] scaled;
    int          pick;
    bit          found;
    status_e     st;
    st = ST_OK;
    case (req.cmd)
      CMD_GENERATE: begin
        if (tbl_count == 0) begin
          expect_result(ST_EMPTY, cur_index, 1'b1);
        end else if (multi_mode) begin
          for (int i = 0; i < tbl_count; i++)
            expect_result(ST_OK, SRC_W'(i), i + 1 == tbl_count);
        end else if (tbl_count == 1) begin
          expect_result(ST_OK, '0, 1'b1);
        end else begin
          total = '0;
          for (int i = 0; i < tbl_count; i++)
            total += 64'(tbl_weight[i]);
          if (total == 0) begin
            expect_result(ST_EMPTY, cur_index, 1'b1);
          end else begin
            scaled = 64'(req.fraction) * total;
            prefix = '0;
            found  = 1'b0;
            pick   = tbl_count - 1;
            for (int i = 0; i < tbl_count; i++) begin
              prefix += 64'(tbl_weight[i]);
              if (!found && scaled <= (prefix << RAND_W)) begin
                pick  = i;
                found = 1'b1;
              end
            end
            expect_result(ST_OK, SRC_W'(pick), 1'b1);
          end
        end
        return;
      end
      CMD_ADD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          st = ST_FULL;
        end else begin
          tbl_weight[tbl_count] = req.weight;
          cur_index = SRC_W'(tbl_count);
          cur_valid = 1'b1;
          tbl_count++;
        end
      end
      CMD_SELECT: begin
        if (req.entry < tbl_count) begin
          cur_index = req.entry;
          cur_valid = 1'b1;
        end else begin
          st = ST_BAD_INDEX;
        end
      end
      CMD_SET: begin
        if (cur_valid && cur_index < tbl_count) tbl_weight[cur_index] = req.weight;
        else st = ST_EMPTY;
      end
      CMD_DELETE: begin
        if (req.entry < tbl_count) begin
          for (int i = req.entry; i + 1 < tbl_count; i++)
            tbl_weight[i] = tbl_weight[i + 1];
          tbl_count--;
          if (cur_index == req.entry) begin
            cur_index = '0;
            cur_valid = tbl_count > 0;
          end else if (cur_index > req.entry) begin
            cur_index--;
          end
        end else begin
          st = ST_BAD_INDEX;
        end
      end
      CMD_CLEAR: begin
        tbl_count = '0;
        cur_index = '0;
        cur_valid = 1'b0;
      end
      default: ;
    endcase
    expect_result(st, cur_index, 1'b1);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch in %s: got %0d, want %0d", field, got, want);
    mismatches++;
  endtask

  // Driver: present pending requests, holding back on idle bursts and drain requests.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    bit       taken;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else begin
      taken = s_axis_tvalid && s_axis_tready;
      if (taken) apply_command(cur_request);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].hold && (taken || !results_drained))) begin
          nxt = pending_requests.pop_front();
          cur_request   = nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_TDATA_W'({nxt.fraction, nxt.entry, nxt.weight});
          s_axis_tuser  <= nxt.cmd;
          if (!no_idle && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 15);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) results_drained = expected_results.size() == 0;

  // Monitor: stall the result stream in bursts and check each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing due", int'(m_axis_tdata), 0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser != want.status)
            report_mismatch("status", int'(m_axis_tuser), int'(want.status));
          if (m_axis_tdata[SRC_W-1:0] != want.source)
            report_mismatch("source_index", int'(m_axis_tdata[SRC_W-1:0]), int'(want.source));
          if (m_axis_tlast != want.last)
            report_mismatch("last", int'(m_axis_tlast), int'(want.last));
          if (m_axis_tdata[SRC_W +: SCNT_W] != want.count)
            report_mismatch("source_count", int'(m_axis_tdata[SRC_W +: SCNT_W]),
                            int'(want.count));
        end
      end
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left    <= $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return WEIGHT_W'($urandom_range(1, 15));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAND_W-1:0] pick_fraction();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return RAND_W'($urandom);
    endcase
  endfunction

  function automatic logic [EIDX_W-1:0] pick_entry();
    if ($urandom_range(0, 1)) return EIDX_W'($urandom_range(0, 3));
    return EIDX_W'($urandom_range(0, 15));
  endfunction

  task automatic queue_request(logic [CMD_W-1:0] cmd, logic [WEIGHT_W-1:0] weight,
                               logic [EIDX_W-1:0] entry, logic [RAND_W-1:0] fraction,
                               bit hold);
    request_t r;
    r.cmd      = cmd;
    r.weight   = weight;
    r.entry    = entry;
    r.fraction = fraction;
    r.hold     = hold;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic queue_fill();
    queue_request(CMD_CLEAR, pick_weight(), pick_entry(), pick_fraction(), 1'b0);
    repeat (TABLE_DEPTH + 1)
      queue_request(CMD_ADD, pick_weight(), pick_entry(), pick_fraction(), 1'b0);
    queue_request(CMD_GENERATE, pick_weight(), pick_entry(), pick_fraction(), 1'b0);
  endtask

  task automatic queue_random(int n);
    int               roll;
    logic [CMD_W-1:0] cmd;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        queue_fill();
        k += TABLE_DEPTH + 2;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 35)      cmd = CMD_GENERATE;
        else if (roll < 55) cmd = CMD_ADD;
        else if (roll < 65) cmd = CMD_SELECT;
        else if (roll < 75) cmd = CMD_SET;
        else if (roll < 88) cmd = CMD_DELETE;
        else if (roll < 92) cmd = CMD_CLEAR;
        else if (roll < 96) cmd = CMD_SPARE_A;
        else                cmd = CMD_SPARE_B;
        queue_request(cmd, pick_weight(), pick_entry(), pick_fraction(),
                      $urandom_range(0, 15) == 0);
      end
    end
  endtask

  task automatic write_mode(bit m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    multi_mode = m;
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    tbl_weight[0] = WEIGHT_W'(1);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_mode(1'b0);
    @(negedge clk_i);
    queue_request(CMD_GENERATE, '0, '0, '1, 1'b0);
    queue_request(CMD_SET, '0, '0, '0, 1'b0);
    queue_request(CMD_GENERATE, '0, '0, '0, 1'b0);
    queue_request(CMD_ADD, '0, '0, '0, 1'b0);
    queue_request(CMD_GENERATE, '0, '0, 24'h800000, 1'b1);
    queue_request(CMD_ADD, '1, '1, '0, 1'b0);
    queue_request(CMD_GENERATE, '0, '0, '0, 1'b0);
    queue_request(CMD_GENERATE, '0, '0, '1, 1'b0);
    queue_request(CMD_SELECT, '0, 4'd1, '0, 1'b0);
    queue_request(CMD_SET, '1, '0, '0, 1'b0);
    queue_request(CMD_SELECT, '0, '1, '0, 1'b0);
    queue_request(CMD_DELETE, '0, '0, '0, 1'b0);
    queue_request(CMD_SPARE_A, '1, '1, '1, 1'b0);
    queue_request(CMD_SPARE_B, '0, '0, '0, 1'b0);
    queue_request(CMD_ADD, WEIGHT_W'(1), '0, '0, 1'b0);
    queue_request(CMD_DELETE, '0, 4'd2, '0, 1'b0);
    queue_request(CMD_CLEAR, '0, '0, '0, 1'b0);
    queue_request(CMD_GENERATE, '0, '0, '1, 1'b0);
    queue_request(CMD_SET, WEIGHT_W'(7), '0, '0, 1'b0);
    queue_request(CMD_SELECT, '0, '0, '0, 1'b0);
    queue_request(CMD_DELETE, '0, '0, '0, 1'b0);
    queue_request(CMD_ADD, '1, '0, '0, 1'b0);
    settle();

    write_mode(1'b1);
    @(negedge clk_i);
    queue_request(CMD_GENERATE, '0, '0, '0, 1'b0);
    queue_request(CMD_CLEAR, '0, '0, '0, 1'b0);
    queue_request(CMD_GENERATE, '0, '0, '0, 1'b0);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_mode(1'(ph % 2));
      @(negedge clk_i);
      if (ph == 3) no_idle = 1'b1;
      if (ph == 1) queue_fill();
      queue_random(20);
      settle();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
